/* sv/sd_host_register_card_model_unit_defines.svh */
// Assertion macros shared by the SD host register block modules.
// Needs signals named clk and rst in the scope of each use.
`ifndef SD_HOST_REGISTER_CARD_MODEL_UNIT_DEFINES_SVH
`define SD_HOST_REGISTER_CARD_MODEL_UNIT_DEFINES_SVH

`ifndef NO_ASSERTIONS
`define SDHRC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define SDHRC_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define SDHRC_ASSERT(lbl, prop, msg)
`define SDHRC_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

/* sv/sdhrc_pkg.sv */
// Shared types, register map, command codes and card constants of the
// SD host register block. No dependencies.
`timescale 1ns / 1ps

package sdhrc_pkg;

  localparam int IMAGE_AW    = 16;
  localparam int IMAGE_WORDS = 1 << IMAGE_AW;
  localparam int BLOCK_SHIFT = 7;

  localparam int S_TDATA_W = 40;
  localparam int M_TDATA_W = 40;

  localparam logic [4:0] REG_CMD  = 5'd0;
  localparam logic [4:0] REG_ARG  = 5'd1;
  localparam logic [4:0] REG_RSP0 = 5'd4;
  localparam logic [4:0] REG_RSP3 = 5'd7;
  localparam logic [4:0] REG_DATA = 5'd16;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_BAD_REG = 2'd1;
  localparam logic [1:0] ST_BAD_CMD = 2'd2;

  localparam logic [5:0] CMD_GO_IDLE      = 6'd0;
  localparam logic [5:0] CMD_SEND_OP_COND = 6'd1;
  localparam logic [5:0] CMD_ALL_SEND_CID = 6'd2;
  localparam logic [5:0] CMD_SET_RCA      = 6'd3;
  localparam logic [5:0] CMD_SLEEP_AWAKE  = 6'd5;
  localparam logic [5:0] CMD_SELECT       = 6'd7;
  localparam logic [5:0] CMD_SEND_EXT_CSD = 6'd8;
  localparam logic [5:0] CMD_SEND_CSD     = 6'd9;
  localparam logic [5:0] CMD_STOP         = 6'd12;
  localparam logic [5:0] CMD_SEND_STATUS  = 6'd13;
  localparam logic [5:0] CMD_READ_MULTI   = 6'd18;
  localparam logic [5:0] CMD_SET_BLOCKS   = 6'd23;
  localparam logic [5:0] CMD_IO_RW_DIRECT = 6'd52;
  localparam logic [5:0] CMD_APP_CMD      = 6'd55;

  localparam logic [5:0] CMD_WRITE_MULTI  = 6'd25;

  localparam logic [31:0] OCR_VALUE  = 32'h80ff8000;
  localparam logic [31:0] CID_WORD0  = 32'h00000001;
  localparam logic [31:0] CID_WORD3  = 32'h15000000;
  localparam logic [31:0] CSD_WORD0  = 32'h92404001;
  localparam logic [31:0] CSD_WORD1  = 32'hd24b97e3;
  localparam logic [31:0] CSD_WORD2  = 32'h0f5f80ff;
  localparam logic [31:0] CSD_WORD3  = 32'h9026012a;
  localparam logic [31:0] CARD_STATUS = 32'h00000900;

  localparam logic [31:0] EXT_REV_OFS  = 32'd192;
  localparam logic [31:0] EXT_SEC_OFS  = 32'd212;
  localparam logic [31:0] EXT_LAST_OFS = 32'd508;
  localparam logic [31:0] EXT_REV_VAL  = 32'h00000002;
  localparam logic [31:0] EXT_SEC_VAL  = 32'h02000000;
  localparam logic [31:0] WORD_BYTES   = 32'd4;

  typedef enum logic [2:0] {
    KIND_CMD,
    KIND_ARG,
    KIND_RSP,
    KIND_DATA,
    KIND_BAD
  } kind_t;

  typedef struct packed {
    logic        wr;
    kind_t       kind;
    logic [1:0]  rsp_sel;
    logic [31:0] wdata;
  } queue_item_t;

  function automatic logic cmd_known(input logic [5:0] code);
    logic known;
    case (code) inside
      CMD_GO_IDLE, CMD_SEND_OP_COND, CMD_ALL_SEND_CID, CMD_SET_RCA,
      CMD_SLEEP_AWAKE, CMD_SELECT, CMD_SEND_EXT_CSD, CMD_SEND_CSD,
      CMD_STOP, CMD_SEND_STATUS, CMD_READ_MULTI, CMD_SET_BLOCKS,
      CMD_WRITE_MULTI, CMD_IO_RW_DIRECT, CMD_APP_CMD: known = 1'b1;
      default: known = 1'b0;
    endcase
    return known;
  endfunction

endpackage

/* sv/sd_host_register_card_model_unit.sv */
// Channel  Dir  Fields (lowest bit first)                     Accepted when
// s_*      in   opcode, word_index[4:0], write_data[31:0]      s_tvalid && s_tready
// m_*      out  read_data[31:0], status[1:0]                   m_tvalid && m_tready
// One word per cycle while neither the memory clear nor m_tready back-pressure stalls intake.
// After reset the whole image memory is zeroed one word a cycle; no words are taken meanwhile.
// A two-entry queue decouples intake from execution; one output register holds the result.
// Top level of the SD host register block; depends on sdhrc_pkg, sdhrc_front,
// sdhrc_queue and sdhrc_back.
`timescale 1ns / 1ps

module sd_host_register_card_model_unit (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_tvalid,
  output logic                            s_tready,
  input  logic [sdhrc_pkg::S_TDATA_W-1:0] s_tdata, // opcode, word_index[4:0], write_data[31:0]
  output logic                            m_tvalid,
  input  logic                            m_tready,
  output logic [sdhrc_pkg::M_TDATA_W-1:0] m_tdata  // read_data[31:0], status[1:0]
);
  import sdhrc_pkg::*;

  logic        q_push;
  logic        q_full;
  logic        q_pop;
  logic        q_valid;
  logic        clearing;
  queue_item_t push_item;
  queue_item_t head_item;

  sdhrc_front u_front (
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .q_full   (q_full),
    .clearing (clearing),
    .q_push   (q_push),
    .q_item   (push_item)
  );

  sdhrc_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (q_push),
    .push_item  (push_item),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (q_valid),
    .head_item  (head_item)
  );

  sdhrc_back u_back (
    .clk      (clk),
    .rst      (rst),
    .q_valid  (q_valid),
    .q_item   (head_item),
    .q_pop    (q_pop),
    .clearing (clearing),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

endmodule

/* sv/sdhrc_front.sv */
// Front end: takes bus words from the slave stream and classifies the register.
// Depends on sdhrc_pkg.
`timescale 1ns / 1ps

module sdhrc_front (
  input  logic                        s_tvalid,
  output logic                        s_tready,
  input  logic [sdhrc_pkg::S_TDATA_W-1:0] s_tdata, // opcode, word_index[4:0], write_data[31:0]
  input  logic                        q_full,
  input  logic                        clearing,
  output logic                        q_push,
  output sdhrc_pkg::queue_item_t      q_item
);
  import sdhrc_pkg::*;

  logic [4:0] idx;

  assign idx      = s_tdata[5:1];
  assign s_tready = !q_full && !clearing;
  assign q_push   = s_tvalid && s_tready;

  always_comb begin
    q_item.wr      = s_tdata[0];
    q_item.wdata   = s_tdata[37:6];
    q_item.rsp_sel = idx[1:0];
    unique case (idx) inside
      REG_CMD:             q_item.kind = KIND_CMD;
      REG_ARG:             q_item.kind = KIND_ARG;
      [REG_RSP0:REG_RSP3]: q_item.kind = KIND_RSP;
      REG_DATA:            q_item.kind = KIND_DATA;
      default:             q_item.kind = KIND_BAD;
    endcase
  end

endmodule

/* sv/sdhrc_queue.sv */
// Two-entry queue between the front end and the execution back end.
// Depends on sdhrc_pkg and the assertion macro header.
`timescale 1ns / 1ps
`include "sd_host_register_card_model_unit_defines.svh"

module sdhrc_queue (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   push,
  input  sdhrc_pkg::queue_item_t push_item,
  output logic                   full,
  input  logic                   pop,
  output logic                   head_valid,
  output sdhrc_pkg::queue_item_t head_item
);
  import sdhrc_pkg::*;

  queue_item_t entry [2];
  logic        wr_ptr;
  logic        rd_ptr;
  logic [1:0]  count;

  assign full       = (count == 2'd2);
  assign head_valid = (count != 2'd0);
  assign head_item  = entry[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entry[wr_ptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
      end
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end

  `SDHRC_ASSERT(a_no_underflow, pop |-> (count != 2'd0), "queue popped while empty")
  `SDHRC_ASSERT(a_no_overflow, push |-> (count != 2'd2) || pop, "queue pushed while full")

endmodule

/* sv/sdhrc_back.sv */
// Back end: executes queued words against the register state, the card
// model and the image memory; drives the master stream. Depends on sdhrc_pkg and the assertion macro header.
`timescale 1ns / 1ps
`include "sd_host_register_card_model_unit_defines.svh"

module sdhrc_back (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        q_valid,
  input  sdhrc_pkg::queue_item_t      q_item,
  output logic                        q_pop,
  output logic                        clearing,
  output logic                        m_tvalid,
  input  logic                        m_tready,
  output logic [sdhrc_pkg::M_TDATA_W-1:0] m_tdata // read_data[31:0], status[1:0]
);
  import sdhrc_pkg::*;

  logic [31:0] command_word, command_word_next;
  logic [31:0] argument_word, argument_word_next;
  logic [31:0] rsp [4];
  logic [31:0] rsp_next [4];
  logic [31:0] data_word, data_word_next;
  logic        dw_from_ram, dw_from_ram_next;
  logic [31:0] transfer_byte_offset, transfer_byte_offset_next;
  logic [IMAGE_AW-1:0] image_ptr, image_ptr_next;
  logic        write_transfer, write_transfer_next;
  logic        ext_csd_active, ext_csd_active_next;
  logic [IMAGE_AW-1:0] clr_addr;

  logic [31:0] image_mem [IMAGE_WORDS];
  logic [31:0] mem_rdata;
  logic        mem_we;
  logic        mem_re;
  logic [IMAGE_AW-1:0] mem_addr;
  logic [31:0] mem_wdata;

  logic        out_valid;
  logic [31:0] out_rd;
  logic [1:0]  out_st;
  logic        out_from_ram;

  logic        exec;
  logic        ext_last;
  logic [31:0] cw;
  logic [5:0]  code;
  logic [31:0] dw_eff;
  logic [31:0] dw_in;
  logic [31:0] rd_val;
  logic [1:0]  st_val;
  logic        rd_from_ram;
  logic [31+BLOCK_SHIFT:0] arg_scaled;

  assign exec       = q_valid && !clearing && (!out_valid || m_tready);
  assign q_pop      = exec;
  assign ext_last   = exec && (transfer_byte_offset == EXT_LAST_OFS);
  assign dw_eff     = dw_from_ram ? mem_rdata : data_word;
  assign cw         = q_item.wr ? q_item.wdata : command_word;
  assign code       = cw[5:0];
  assign dw_in      = q_item.wr ? q_item.wdata : dw_eff;
  assign arg_scaled = {argument_word, {BLOCK_SHIFT{1'b0}}};

  always_comb begin
    command_word_next         = command_word;
    argument_word_next        = argument_word;
    rsp_next                  = rsp;
    data_word_next            = data_word;
    dw_from_ram_next          = dw_from_ram;
    transfer_byte_offset_next = transfer_byte_offset;
    image_ptr_next            = image_ptr;
    write_transfer_next       = write_transfer;
    ext_csd_active_next       = ext_csd_active;
    rd_val                    = '0;
    st_val                    = ST_OK;
    rd_from_ram               = 1'b0;
    mem_we                    = 1'b0;
    mem_re                    = 1'b0;
    mem_addr                  = image_ptr;
    mem_wdata                 = dw_in;
    if (clearing) begin
      mem_we    = 1'b1;
      mem_addr  = clr_addr;
      mem_wdata = '0;
    end else if (exec) begin
      unique case (q_item.kind)
        KIND_CMD: begin
          if (cmd_known(code)) begin
            command_word_next = cw;
            rd_val            = cw;
            unique case (code)
              CMD_SEND_OP_COND: rsp_next[0] = OCR_VALUE;
              CMD_ALL_SEND_CID: begin
                rsp_next[0] = CID_WORD0;
                rsp_next[1] = '0;
                rsp_next[2] = '0;
                rsp_next[3] = CID_WORD3;
              end
              CMD_SEND_EXT_CSD: begin
                ext_csd_active_next       = 1'b1;
                transfer_byte_offset_next = '0;
              end
              CMD_SEND_CSD: begin
                rsp_next[0] = CSD_WORD0;
                rsp_next[1] = CSD_WORD1;
                rsp_next[2] = CSD_WORD2;
                rsp_next[3] = CSD_WORD3;
              end
              CMD_SEND_STATUS: begin
                rsp_next[0] = CARD_STATUS;
                rsp_next[1] = '0;
                rsp_next[2] = '0;
                rsp_next[3] = '0;
              end
              CMD_READ_MULTI, CMD_WRITE_MULTI: begin
                image_ptr_next            = arg_scaled[IMAGE_AW-1:0];
                transfer_byte_offset_next = '0;
                write_transfer_next       = (code == CMD_WRITE_MULTI);
              end
              default: ;
            endcase
          end else begin
            st_val = ST_BAD_CMD;
          end
        end
        KIND_ARG: begin
          if (q_item.wr) begin
            argument_word_next = q_item.wdata;
          end
          rd_val = q_item.wr ? q_item.wdata : argument_word;
        end
        KIND_RSP: begin
          if (q_item.wr) begin
            rsp_next[q_item.rsp_sel] = q_item.wdata;
          end
          rd_val = q_item.wr ? q_item.wdata : rsp[q_item.rsp_sel];
        end
        KIND_DATA: begin
          transfer_byte_offset_next = transfer_byte_offset + WORD_BYTES;
          if (ext_csd_active) begin
            if (transfer_byte_offset == EXT_REV_OFS) begin
              rd_val = EXT_REV_VAL;
            end else if (transfer_byte_offset == EXT_SEC_OFS) begin
              rd_val = EXT_SEC_VAL;
            end else begin
              rd_val = '0;
            end
            if (transfer_byte_offset == EXT_LAST_OFS) begin
              ext_csd_active_next = 1'b0;
            end
            data_word_next   = rd_val;
            dw_from_ram_next = 1'b0;
          end else begin
            image_ptr_next = image_ptr + IMAGE_AW'(1);
            if (write_transfer) begin
              mem_we           = 1'b1;
              data_word_next   = dw_in;
              dw_from_ram_next = 1'b0;
              rd_val           = dw_in;
            end else begin
              mem_re           = 1'b1;
              dw_from_ram_next = 1'b1;
              rd_from_ram      = 1'b1;
            end
          end
        end
        default: st_val = ST_BAD_REG;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      image_mem[mem_addr] <= mem_wdata;
    end
    if (mem_re) begin
      mem_rdata <= image_mem[mem_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      command_word         <= '0;
      argument_word        <= '0;
      rsp                  <= '{default: '0};
      data_word            <= '0;
      dw_from_ram          <= 1'b0;
      transfer_byte_offset <= '0;
      image_ptr            <= '0;
      write_transfer       <= 1'b0;
      ext_csd_active       <= 1'b0;
      clearing             <= 1'b1;
      clr_addr             <= '0;
      out_valid            <= 1'b0;
    end else begin
      command_word         <= command_word_next;
      argument_word        <= argument_word_next;
      rsp                  <= rsp_next;
      data_word            <= data_word_next;
      dw_from_ram          <= dw_from_ram_next;
      transfer_byte_offset <= transfer_byte_offset_next;
      image_ptr            <= image_ptr_next;
      write_transfer       <= write_transfer_next;
      ext_csd_active       <= ext_csd_active_next;
      if (clearing) begin
        clr_addr <= clr_addr + IMAGE_AW'(1);
        if (clr_addr == {IMAGE_AW{1'b1}}) begin
          clearing <= 1'b0;
        end
      end
      if (exec) begin
        out_valid <= 1'b1;
      end else if (m_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (exec) begin
      out_rd       <= rd_val;
      out_st       <= st_val;
      out_from_ram <= rd_from_ram;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {{(M_TDATA_W-34){1'b0}}, out_st, out_from_ram ? mem_rdata : out_rd};

  `SDHRC_ASSERT(a_no_exec_in_clear, clearing |-> !exec, "word executed during memory clear")
  `SDHRC_ASSERT(a_one_mem_op, !(mem_we && mem_re), "image memory read and written together")
  `SDHRC_ASSERT(a_ext_end, $fell(ext_csd_active) |-> $past(rst) || $past(ext_last), "EXT_CSD ended early")

endmodule
